### rtl/core/rcasr_pkg.sv
`timescale 1ns / 1ps
package rcasr_pkg;

    // Field widths
    localparam int UNITS_W = 64;
    localparam int DEN_W   = 63;
    localparam int PROD_W  = 192;
    localparam int NUM_W   = 191;
    localparam int DIV_W   = 127;
    localparam int DIGIT_W = 8;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_SUB   = 2'd1,
        REQ_SCALE = 2'd2,
        REQ_PASS  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        RND_HALF_EVEN   = 3'd0,
        RND_HALF_UP     = 3'd1,
        RND_HALF_DOWN   = 3'd2,
        RND_AWAY        = 3'd3,
        RND_TOWARD_ZERO = 3'd4
    } round_mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_RATE = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // Per-item control carried alongside the arithmetic
    typedef struct packed {
        req_type_t   req;
        round_mode_t mode;
        logic [UNITS_W-1:0] base;
        logic        neg;
        status_t     err;
    } side_t;

    function automatic logic [UNITS_W-1:0] mag64(input logic [UNITS_W-1:0] x);
        return x[UNITS_W-1] ? (~x + UNITS_W'(1)) : x;
    endfunction

endpackage

### rtl/core/rcasr_mul.sv
`timescale 1ns / 1ps
module rcasr_mul #(
    parameter int A_W    = 64,
    parameter int B_W    = 64,
    parameter int SIDE_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_vld,
    output logic [A_W+B_W-1:0]   p,
    output logic [SIDE_W-1:0]    side_out
);
    import rcasr_pkg::*;

    localparam int P_W   = A_W + B_W;
    localparam int STEPS = B_W / DIGIT_W;

    logic              vld_reg  [STEPS];
    logic [P_W-1:0]    acc_reg  [STEPS];
    logic [A_W-1:0]    a_reg    [STEPS];
    logic [B_W-1:0]    b_reg    [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            logic              vld_in;
            logic [P_W-1:0]    acc_in;
            logic [A_W-1:0]    a_in;
            logic [B_W-1:0]    b_in;
            logic [SIDE_W-1:0] side_in_k;
            logic [A_W+DIGIT_W-1:0] pp;
            logic [P_W-1:0]    acc_next;

            // Take the previous step or the port
            if (k == 0) begin : g_first
                assign vld_in    = in_vld;
                assign acc_in    = '0;
                assign a_in      = a;
                assign b_in      = b;
                assign side_in_k = side_in;
            end else begin : g_rest
                assign vld_in    = vld_reg[k-1];
                assign acc_in    = acc_reg[k-1];
                assign a_in      = a_reg[k-1];
                assign b_in      = b_reg[k-1];
                assign side_in_k = side_reg[k-1];
            end

            // Add one digit's partial product
            assign pp       = a_in * b_in[k*DIGIT_W +: DIGIT_W];
            assign acc_next = acc_in + (P_W'(pp) << (k * DIGIT_W));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    acc_reg[k]  <= acc_next;
                    a_reg[k]    <= a_in;
                    b_reg[k]    <= b_in;
                    side_reg[k] <= side_in_k;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[STEPS-1];
    assign p        = acc_reg[STEPS-1];
    assign side_out = side_reg[STEPS-1];

endmodule

### rtl/core/rcasr_div.sv
`timescale 1ns / 1ps
module rcasr_div #(
    parameter int SIDE_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [rcasr_pkg::NUM_W-1:0]   nm,
    input  logic [rcasr_pkg::DIV_W-1:0]   dm,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_vld,
    output logic [rcasr_pkg::NUM_W-1:0]   quot,
    output logic [rcasr_pkg::DIV_W-1:0]   rem,
    output logic [rcasr_pkg::DIV_W-1:0]   dm_out,
    output logic [SIDE_W-1:0]             side_out
);
    import rcasr_pkg::*;

    logic              vld_reg  [NUM_W];
    logic [DIV_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  qn_reg   [NUM_W];
    logic [DIV_W-1:0]  dm_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_bit
            logic              vld_in;
            logic [DIV_W-1:0]  rem_in;
            logic [NUM_W-1:0]  qn_in;
            logic [DIV_W-1:0]  dm_in;
            logic [SIDE_W-1:0] side_in_k;
            logic [DIV_W:0]    trial;
            logic [DIV_W+1:0]  diff;
            logic              ge;

            if (k == 0) begin : g_first
                assign vld_in    = in_vld;
                assign rem_in    = '0;
                assign qn_in     = nm;
                assign dm_in     = dm;
                assign side_in_k = side_in;
            end else begin : g_rest
                assign vld_in    = vld_reg[k-1];
                assign rem_in    = rem_reg[k-1];
                assign qn_in     = qn_reg[k-1];
                assign dm_in     = dm_reg[k-1];
                assign side_in_k = side_reg[k-1];
            end

            // Bring down one dividend bit and try the subtract
            assign trial = {rem_in, qn_in[NUM_W-1]};
            assign diff  = {1'b0, trial} - {2'b00, dm_in};
            assign ge    = ~diff[DIV_W+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                    qn_reg[k]   <= {qn_in[NUM_W-2:0], ge};
                    dm_reg[k]   <= dm_in;
                    side_reg[k] <= side_in_k;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[NUM_W-1];
    assign quot     = qn_reg[NUM_W-1];
    assign rem      = rem_reg[NUM_W-1];
    assign dm_out   = dm_reg[NUM_W-1];
    assign side_out = side_reg[NUM_W-1];

endmodule

### rtl/core/rate_convert_add_scale_rounded_core.sv
`timescale 1ns / 1ps
// Rate-converting add/subtract and rational scale with selectable rounding.
// Input words arrive on s_t*: tuser carries the request kind and rounding
// mode, tdata the amounts, rates and scale factor. Each accepted word gives
// exactly one output word on m_t*: tdata the result amount, tuser the status
// (ok, zero rate, overflow); the amount is zero whenever status is not ok.
// Add/subtract: base +/- round(other*onum*tden / (oden*tnum)).
// Scale: round(base*fnum/fden). Products are exact to 192 bits.
// The pipe has 211 register stages: one operand stage, two 8-step digit
// multipliers in series (8 bits of multiplier per stage; the divisor product
// runs beside the first), a 191-stage restoring divider (one quotient bit
// per stage) and three stages for rounding, sign and the final add with
// range check. One word is accepted per cycle while m_tready does not
// hold the pipe; the divider stages set the depth.
// Reset clears every valid bit; no state survives between words.
// When m_tready is low with a word waiting, the whole pipe holds and
// s_tready drops in the same cycle; nothing is lost or repeated.
module rate_convert_add_scale_rounded_core #(
    parameter int UNIT_WIDTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // base_units, this_rate_num, this_rate_den, other_units,
    // other_rate_num, other_rate_den, factor_num, factor_den, zero pad
    input  logic [511:0] s_tdata,
    // req_type, rounding_mode
    input  logic [4:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_units
    output logic [63:0]  m_tdata,
    // status
    output logic [1:0]   m_tuser
);
    import rcasr_pkg::*;

    localparam int SIDE_W = $bits(side_t);

    logic en;

    // Unpack the input word
    logic [UNITS_W-1:0] f_base, f_tnum, f_ou, f_on, f_fn;
    logic [DEN_W-1:0]   f_tden, f_od, f_fd;
    req_type_t          f_req;
    logic               is_scale;

    assign f_base = s_tdata[63:0];
    assign f_tnum = s_tdata[127:64];
    assign f_tden = s_tdata[190:128];
    assign f_ou   = s_tdata[254:191];
    assign f_on   = s_tdata[318:255];
    assign f_od   = s_tdata[381:319];
    assign f_fn   = s_tdata[445:382];
    assign f_fd   = s_tdata[508:446];
    assign f_req  = req_type_t'(s_tuser[1:0]);
    assign is_scale = (f_req == REQ_SCALE);

    // Operand stage
    logic               op_vld_reg;
    logic [UNITS_W-1:0] op_a_reg, op_b_reg, op_db_reg, op_m2b_reg;
    logic [DEN_W-1:0]   op_da_reg;
    side_t              op_side_reg;
    side_t              op_side_next;

    always_comb
    begin
        op_side_next.req  = f_req;
        op_side_next.mode = round_mode_t'(s_tuser[4:2]);
        op_side_next.base = f_base;
        op_side_next.neg  = is_scale ? (f_base[63] ^ f_fn[63])
                                     : (f_ou[63] ^ f_on[63] ^ f_tnum[63]);
        case (f_req)
            REQ_ADD, REQ_SUB:
            begin
                if (f_tnum == '0)
                    op_side_next.err = ST_ZERO_RATE;
                else if (f_od == '0)
                    op_side_next.err = ST_OVERFLOW;
                else
                    op_side_next.err = ST_OK;
            end
            REQ_SCALE: op_side_next.err = (f_fd == '0) ? ST_OVERFLOW : ST_OK;
            default:   op_side_next.err = ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            op_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_a_reg    <= is_scale ? mag64(f_base) : mag64(f_ou);
            op_b_reg    <= is_scale ? mag64(f_fn) : mag64(f_on);
            op_da_reg   <= is_scale ? f_fd : f_od;
            op_db_reg   <= is_scale ? UNITS_W'(1) : mag64(f_tnum);
            op_m2b_reg  <= is_scale ? UNITS_W'(1) : {1'b0, f_tden};
            op_side_reg <= op_side_next;
        end
    end

    // First products: numerator magnitude pair and divisor
    logic                   m1_vld;
    logic [2*UNITS_W-1:0]   m1_p;
    logic [SIDE_W-1:0]      m1_side;
    logic [DIV_W-1:0]       md_p;
    logic [UNITS_W-1:0]     md_side;

    rcasr_mul #(.A_W(UNITS_W), .B_W(UNITS_W), .SIDE_W(SIDE_W)) u_mul_num (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (op_vld_reg),
        .a        (op_a_reg),
        .b        (op_b_reg),
        .side_in  (op_side_reg),
        .out_vld  (m1_vld),
        .p        (m1_p),
        .side_out (m1_side)
    );

    rcasr_mul #(.A_W(DEN_W), .B_W(UNITS_W), .SIDE_W(UNITS_W)) u_mul_den (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (op_vld_reg),
        .a        (op_da_reg),
        .b        (op_db_reg),
        .side_in  (op_m2b_reg),
        .out_vld  (),
        .p        (md_p),
        .side_out (md_side)
    );

    // Second product: times this rate's denominator (or one for scale)
    logic                      m2_vld;
    logic [PROD_W-1:0]         m2_p;
    logic [DIV_W+SIDE_W-1:0]   m2_side;

    rcasr_mul #(.A_W(2*UNITS_W), .B_W(UNITS_W), .SIDE_W(DIV_W+SIDE_W)) u_mul_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (m1_vld),
        .a        (m1_p),
        .b        (md_side),
        .side_in  ({md_p, m1_side}),
        .out_vld  (m2_vld),
        .p        (m2_p),
        .side_out (m2_side)
    );

    // Long division of magnitudes
    logic              dv_vld;
    logic [NUM_W-1:0]  dv_q;
    logic [DIV_W-1:0]  dv_rem, dv_dm;
    logic [SIDE_W-1:0] dv_side;

    rcasr_div #(.SIDE_W(SIDE_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (m2_vld),
        .nm       (m2_p[NUM_W-1:0]),
        .dm       (m2_side[DIV_W+SIDE_W-1:SIDE_W]),
        .side_in  (m2_side[SIDE_W-1:0]),
        .out_vld  (dv_vld),
        .quot     (dv_q),
        .rem      (dv_rem),
        .dm_out   (dv_dm),
        .side_out (dv_side)
    );

    // Rounding decision
    side_t            dv_s;
    logic [DIV_W:0]   r2, dmx;
    logic             r_gt, r_eq, r_nz, up_next;
    logic             rd_vld_reg, rd_up_reg;
    logic [NUM_W-1:0] rd_q_reg;
    side_t            rd_side_reg;

    assign dv_s = side_t'(dv_side);
    assign r2   = {dv_rem, 1'b0};
    assign dmx  = {1'b0, dv_dm};
    assign r_gt = (r2 > dmx);
    assign r_eq = (r2 == dmx);
    assign r_nz = (dv_rem != '0);

    always_comb
    begin
        case (dv_s.mode)
            RND_HALF_EVEN: up_next = r_gt || (r_eq && dv_q[0]);
            RND_HALF_UP:   up_next = r_gt || r_eq;
            RND_HALF_DOWN: up_next = r_gt;
            RND_AWAY:      up_next = 1'b1;
            default:       up_next = 1'b0;
        endcase
        up_next = up_next && r_nz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            rd_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_up_reg   <= up_next;
            rd_q_reg    <= dv_q;
            rd_side_reg <= dv_s;
        end
    end

    // Apply rounding and sign: -(q+up) = ~q + !up
    logic [PROD_W-1:0] qx, conv_next;
    logic              cv_vld_reg;
    logic [PROD_W-1:0] cv_conv_reg;
    side_t             cv_side_reg;

    assign qx        = {1'b0, rd_q_reg};
    assign conv_next = rd_side_reg.neg ? (~qx + PROD_W'(!rd_up_reg))
                                       : (qx + PROD_W'(rd_up_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            cv_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cv_conv_reg <= conv_next;
            cv_side_reg <= rd_side_reg;
        end
    end

    // Final add, range check and output register
    logic [PROD_W-1:0]            base_x, sum;
    logic [PROD_W-UNIT_WIDTH:0]   top_bits;
    logic                         fits;
    status_t                      st_next;
    logic                         out_vld_reg;
    logic [UNITS_W-1:0]           out_res_reg;
    status_t                      out_st_reg;

    assign base_x = {{(PROD_W-UNITS_W){cv_side_reg.base[UNITS_W-1]}}, cv_side_reg.base};

    always_comb
    begin
        case (cv_side_reg.req)
            REQ_ADD:   sum = base_x + cv_conv_reg;
            REQ_SUB:   sum = base_x - cv_conv_reg;
            REQ_SCALE: sum = cv_conv_reg;
            default:   sum = base_x;
        endcase
    end

    assign top_bits = sum[PROD_W-1:UNIT_WIDTH-1];
    assign fits     = (&top_bits) || (~|top_bits);

    always_comb
    begin
        if (cv_side_reg.err != ST_OK)
            st_next = cv_side_reg.err;
        else if (!fits)
            st_next = ST_OVERFLOW;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= cv_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_res_reg <= (st_next == ST_OK) ? sum[UNITS_W-1:0] : '0;
            out_st_reg  <= st_next;
        end
    end

    // Advance the whole pipe unless a finished word is held
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_res_reg;
    assign m_tuser  = out_st_reg;

endmodule

### tb/rate_result_checker.sv
`timescale 1ns / 1ps
module rate_result_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [511:0] s_tdata,
    input  logic [4:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           failures,
    output int           pending
);
    import rcasr_pkg::*;

    typedef struct {
        logic [63:0] units;
        status_t     status;
    } amount_t;

    amount_t expected_amounts[$];

    function automatic logic [63:0] magnitude(input logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    // Truncating divide, then let the rounding mode decide whether to grow the magnitude
    function automatic logic signed [199:0] rounded_quotient(input logic [191:0] nm,
                                                             input logic [191:0] dm,
                                                             input logic neg,
                                                             input logic [2:0] mode);
        logic [191:0] q;
        logic [191:0] r;
        logic [192:0] twice;
        logic [192:0] dm_ext;
        logic         up;
        logic [199:0] mag;
        q = nm / dm;
        r = nm % dm;
        twice = {r, 1'b0};
        dm_ext = {1'b0, dm};
        up = 1'b0;
        if (r != '0)
        begin
            case (mode)
                RND_HALF_EVEN: up = (twice > dm_ext) || (twice == dm_ext && q[0]);
                RND_HALF_UP:   up = (twice >= dm_ext);
                RND_HALF_DOWN: up = (twice > dm_ext);
                RND_AWAY:      up = 1'b1;
                default:       up = 1'b0;
            endcase
        end
        mag = {8'd0, q} + 200'(up);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic amount_t predict_amount(input logic [511:0] d, input logic [4:0] u);
        amount_t a;
        logic [1:0]  req;
        logic [2:0]  mode;
        logic [63:0] base, tnum, ounits, onum, fnum;
        logic [62:0] tden, oden, fden;
        logic [191:0] nm, dm;
        logic signed [199:0] conv, res;
        req = u[1:0];
        mode = u[4:2];
        base = d[63:0];
        tnum = d[127:64];
        tden = d[190:128];
        ounits = d[254:191];
        onum = d[318:255];
        oden = d[381:319];
        fnum = d[445:382];
        fden = d[508:446];
        a.units = '0;
        a.status = ST_OK;
        res = {{136{base[63]}}, base};
        if (req == REQ_ADD || req == REQ_SUB)
        begin
            if (tnum == '0)
            begin
                a.status = ST_ZERO_RATE;
                return a;
            end
            nm = 192'(magnitude(ounits)) * 192'(magnitude(onum)) * 192'(tden);
            dm = 192'(oden) * 192'(magnitude(tnum));
            if (dm == '0)
            begin
                a.status = ST_OVERFLOW;
                return a;
            end
            conv = rounded_quotient(nm, dm, ounits[63] ^ onum[63] ^ tnum[63], mode);
            res = (req == REQ_ADD) ? res + conv : res - conv;
        end
        else if (req == REQ_SCALE)
        begin
            if (fden == '0)
            begin
                a.status = ST_OVERFLOW;
                return a;
            end
            nm = 192'(magnitude(base)) * 192'(magnitude(fnum));
            res = rounded_quotient(nm, 192'(fden), base[63] ^ fnum[63], mode);
        end
        // Hold the result only when it fits in 64 signed bits
        if (res[199:63] == '0 || res[199:63] == '1)
            a.units = res[63:0];
        else
            a.status = ST_OVERFLOW;
        return a;
    endfunction

    assign pending = expected_amounts.size();

    // Predict on each input word, compare on each output word
    always @(posedge clk or negedge rst_n)
    begin
        amount_t e;
        if (!rst_n)
        begin
            failures <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_amounts.push_back(predict_amount(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (expected_amounts.size() == 0)
                begin
                    $error("result word with nothing expected: units %0h status %0d",
                           m_tdata, m_tuser);
                    failures <= failures + 1;
                end
                else
                begin
                    e = expected_amounts.pop_front();
                    if (m_tdata !== e.units || m_tuser !== e.status)
                    begin
                        if (m_tdata !== e.units)
                            $error("result_units: expected %0d, actual %0d",
                                   $signed(e.units), $signed(m_tdata));
                        if (m_tuser !== e.status)
                            $error("status: expected %0d, actual %0d", e.status, m_tuser);
                        failures <= failures + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/rate_convert_add_scale_rounded_core_test.sv
`timescale 1ns / 1ps
module rate_convert_add_scale_rounded_core_test;
    import rcasr_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [511:0] s_tdata;
    logic [4:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           failures;
    int           pending;

    int  words_sent;
    int  kind_count[4];
    bit  long_hold;
    bit  calm;

    localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [62:0] MAX63 = 63'h7fff_ffff_ffff_ffff;

    rate_convert_add_scale_rounded_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    rate_result_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .failures(failures), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Signed value of random width, so small and huge magnitudes both turn up
    function automatic logic [63:0] rand_amount();
        logic [63:0] v;
        v = {$urandom, $urandom};
        v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 1))
            v = ~v + 64'd1;
        return v;
    endfunction

    function automatic logic [62:0] rand_den();
        logic [63:0] v;
        if ($urandom_range(0, 40) == 0)
            return '0;
        v = {$urandom, $urandom};
        v = v >> $urandom_range(1, 63);
        return v[62:0];
    endfunction

    // Offer one word, hold it until taken, then idle for a random gap (none when calm)
    task automatic send_word(input req_type_t req, input logic [2:0] mode,
                             input logic [63:0] base, input logic [63:0] tnum,
                             input logic [62:0] tden, input logic [63:0] ounits,
                             input logic [63:0] onum, input logic [62:0] oden,
                             input logic [63:0] fnum, input logic [62:0] fden);
        int gap;
        s_tdata <= {3'd0, fden, fnum, oden, onum, ounits, tden, tnum, base};
        s_tuser <= {mode, req};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        kind_count[req]++;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        req_type_t req;
        logic [63:0] tnum;
        req = req_type_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
        tnum = ($urandom_range(0, 40) == 0) ? 64'd0 : rand_amount();
        send_word(req, 3'($urandom_range(0, 7)), rand_amount(), tnum, rand_den(),
                  rand_amount(), rand_amount(), rand_den(), rand_amount(), rand_den());
    endtask

    // Receiver: random stalls per word, plus one long hold-off
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                long_hold = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int m;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        rst_n = 1'b0;
        words_sent = 0;
        kind_count = '{default: 0};
        long_hold = 1'b0;
        calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: halfway cases in all modes and signs, then error and edge cases
        for (m = 0; m < 8; m++)
        begin
            send_word(REQ_SCALE, 3'(m), 64'd5, 64'd1, 63'd1, 64'd0, 64'd1, 63'd1, 64'd1, 63'd2);
            send_word(REQ_SCALE, 3'(m), -64'sd5, 64'd1, 63'd1, 64'd0, 64'd1, 63'd1,
                      64'd1, 63'd2);
        end
        send_word(REQ_ADD, RND_HALF_EVEN, 64'd100, 64'd3, 63'd2, 64'd7, 64'd5, 63'd4, 0, 63'd1);
        send_word(REQ_SUB, RND_HALF_UP, 64'd100, -64'sd3, 63'd2, -64'sd7, 64'd5, 63'd4, 0, 63'd1);
        send_word(REQ_ADD, RND_AWAY, 64'd1, 64'd0, 63'd1, 64'd1, 64'd1, 63'd1, 0, 63'd1);
        send_word(REQ_SUB, RND_AWAY, 64'd1, 64'd2, 63'd1, 64'd1, 64'd1, 63'd0, 0, 63'd1);
        send_word(REQ_ADD, RND_HALF_DOWN, 64'd9, 64'd2, 63'd0, 64'd1, 64'd1, 63'd1, 0, 63'd1);
        send_word(REQ_SCALE, RND_TOWARD_ZERO, 64'd9, 0, 0, 0, 0, 0, 64'd1, 63'd0);
        send_word(REQ_SCALE, RND_HALF_EVEN, MAX64, 0, 0, 0, 0, 0, 64'd1, 63'd1);
        send_word(REQ_SCALE, RND_HALF_EVEN, MIN64, 0, 0, 0, 0, 0, -64'sd1, 63'd1);
        send_word(REQ_SCALE, RND_AWAY, MIN64, 0, 0, 0, 0, 0, MIN64, MAX63);
        send_word(REQ_ADD, RND_AWAY, MAX64, MIN64, MAX63, MIN64, MIN64, MAX63, MAX64, MAX63);
        send_word(REQ_PASS, RND_HALF_EVEN, MIN64, 0, 0, MAX64, MAX64, 0, MAX64, 0);
        send_word(REQ_PASS, 3'd7, MAX64, MAX64, MAX63, MAX64, MAX64, MAX63, MAX64, MAX63);

        // Random: calm stretch, long receiver hold-off, drain pause
        repeat (1300)
        begin
            calm = (words_sent >= 300 && words_sent < 450);
            if (words_sent == 600)
                long_hold = 1'b1;
            if (words_sent == 900)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_random();
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);

        $display("Sent %0d words: add %0d, subtract %0d, scale %0d, pass-through %0d.",
                 words_sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/rcasr_pkg.sv
rtl/core/rcasr_mul.sv
rtl/core/rcasr_div.sv
rtl/core/rate_convert_add_scale_rounded_core.sv
tb/rate_result_checker.sv
tb/rate_convert_add_scale_rounded_core_test.sv
